[sv/drs_pkg.sv]
// Disk request scheduler package: field widths, register indexes, scheduling
// order codes and the structs passed between the sequencer and compare unit.
// No dependencies.
package drs_pkg;

   localparam int TRACK_W    = 16;
   localparam int DIST_W     = 16;
   localparam int TOTAL_W    = 21;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int ALG_W      = 2;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   typedef enum logic [ALG_W-1:0] {
      ALG_FCFS  = 2'd0,
      ALG_SSTF  = 2'd1,
      ALG_LOOK  = 2'd2,
      ALG_CLOOK = 2'd3
   } alg_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ALGORITHM   = 2'd0,
      REG_START_TRACK = 2'd1,
      REG_DIRECTION   = 2'd2
   } reg_idx_type;

   // running best candidate of a scan
   typedef struct packed {
      logic               found;
      logic [TRACK_W-1:0] val;
      logic [DIST_W-1:0]  span;
      logic               in_a;
   } best_type;

   // verdict of the compare unit on one candidate
   typedef struct packed {
      logic              take;
      logic [DIST_W-1:0] span;
      logic              in_a;
   } pick_type;

   // settings the compare unit needs
   typedef struct packed {
      alg_type            alg;
      logic               dir;
      logic [TRACK_W-1:0] start;
      logic [TRACK_W-1:0] pos;
   } pick_ctl_type;

endpackage

[sv/drs_if.sv]
// Channel interfaces of the disk request scheduler: request, result and
// register write. Depends on drs_pkg.
interface drs_req_if;
   logic                         valid;
   logic                         ready;
   logic [drs_pkg::TRACK_W-1:0]  track;
   logic                         last_request;
   modport source (output valid, output track, output last_request, input ready);
   modport sink   (input valid, input track, input last_request, output ready);
endinterface

interface drs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [drs_pkg::TRACK_W-1:0]  served_track;
   logic [drs_pkg::DIST_W-1:0]   move_distance;
   logic [drs_pkg::TOTAL_W-1:0]  total_seek;
   logic                         final_result;
   logic                         overflow;
   modport source (output valid, output served_track, output move_distance,
                   output total_seek, output final_result, output overflow,
                   input ready);
   modport sink   (input valid, input served_track, input move_distance,
                   input total_seek, input final_result, input overflow,
                   output ready);
endinterface

interface drs_csr_if;
   logic                            valid;
   logic                            ready;
   logic [drs_pkg::CSR_IDX_W-1:0]   index;
   logic [drs_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/drs_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module drs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[sv/drs_pick.sv]
// Shared compare unit: decides whether one stored request beats the best
// candidate so far under the configured service order. Depends on drs_pkg.
module drs_pick (
   input  drs_pkg::pick_ctl_type           ctl,
   input  drs_pkg::best_type               best,
   input  logic [drs_pkg::TRACK_W-1:0]     cand,
   output drs_pkg::pick_type               res
);
   import drs_pkg::*;

   logic [DIST_W-1:0] span;
   logic              in_a;
   logic              asc;
   logic              take;

   always_comb begin
      span = (cand > ctl.pos) ? DIST_W'(cand - ctl.pos) : DIST_W'(ctl.pos - cand);
      // first sweep holds requests on the initial side, head position included
      in_a = ctl.dir ? (cand >= ctl.start) : (cand <= ctl.start);
      asc  = in_a ? ctl.dir : ((ctl.alg == ALG_CLOOK) ? ctl.dir : !ctl.dir);
      unique case (ctl.alg)
         ALG_FCFS: begin
            take = !best.found;
         end
         ALG_SSTF: begin
            take = !best.found || (span < best.span) ||
                   ((span == best.span) && (ctl.dir ? (cand > best.val)
                                                    : (cand < best.val)));
         end
         ALG_LOOK, ALG_CLOOK: begin
            // equal tracks: earliest arrival going up, latest going down
            take = !best.found || (in_a && !best.in_a) ||
                   ((in_a == best.in_a) && (asc ? (cand < best.val)
                                                : (cand >= best.val)));
         end
         default: begin
            take = 1'b0;
         end
      endcase
      res.take = take;
      res.span = span;
      res.in_a = in_a;
   end
endmodule

[sv/disk_request_scheduler.sv]
// Channel   Role     Payload
// req_port  sink     track, last_request
// rsp_port  source   served_track, move_distance, total_seek, final_result, overflow
// csr_port  sink     index, data (always ready)
//
// A request is stored when it is accepted. After the last request of a batch,
// each result comes from one scan over the request RAM's read port through
// the shared compare unit, then is held in the output register while rsp is
// stalled. No request is taken until the batch has been delivered.
// Reset is synchronous; the request RAM needs no clearing.
module disk_request_scheduler #(
   parameter int MAX_REQUESTS = 32,
   parameter int TRACK_BITS   = 16
) (
   input logic        clock,
   input logic        reset,
   drs_req_if.sink    req_port,
   drs_rsp_if.source  rsp_port,
   drs_csr_if.sink    csr_port
);
   import drs_pkg::*;

   localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CW = $clog2(MAX_REQUESTS + 1);
   localparam logic [TRACK_W-1:0] TMASK = (TRACK_BITS >= TRACK_W) ? {TRACK_W{1'b1}}
      : TRACK_W'((64'd1 << TRACK_BITS) - 64'd1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_REQUESTS);

   typedef enum logic [1:0] {S_LOAD, S_SCAN, S_EMIT} state_type;

   state_type             state_ff, state_in;
   alg_type               alg_ff;
   logic [TRACK_W-1:0]    start_ff;
   logic                  dir_ff;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  drop_ff, drop_in;
   logic [MAX_REQUESTS-1:0] marks_ff, marks_in;
   logic [TRACK_W-1:0]    pos_ff, pos_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [CW-1:0]         step_ff, step_in;
   logic [IW-1:0]         scan_ff, scan_in;
   logic                  iss_done_ff, iss_done_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IW-1:0]         rd_idx_ff, rd_idx_in;
   best_type              best_ff, best_in;
   logic [IW-1:0]         bidx_ff, bidx_in;
   logic                  rv_ff, rv_in;
   logic [TRACK_W-1:0]    r_track_ff, r_track_in;
   logic [DIST_W-1:0]     r_dist_ff, r_dist_in;
   logic [TOTAL_W-1:0]    r_total_ff, r_total_in;
   logic                  r_final_ff, r_final_in;

   logic                  req_xfer, rsp_xfer, wr_en;
   logic [TRACK_W-1:0]    rd_data;
   logic [CW-1:0]         n_last;
   logic                  scan_last, cand;
   logic [TOTAL_W:0]      sum;
   pick_ctl_type          pctl;
   pick_type              pres;

   assign req_port.ready = (state_ff == S_LOAD);
   assign csr_port.ready = 1'b1;
   assign req_xfer = req_port.valid && req_port.ready;
   assign rsp_xfer = rv_ff && rsp_port.ready;
   assign wr_en    = req_xfer && (cnt_ff < CNT_MAX);

   drs_ram #(.WIDTH(TRACK_W), .DEPTH(MAX_REQUESTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[IW-1:0]),
      .wr_data (req_port.track & TMASK),
      .rd_addr (scan_ff),
      .rd_data (rd_data)
   );

   assign pctl.alg   = alg_ff;
   assign pctl.dir   = dir_ff;
   assign pctl.start = start_ff & TMASK;
   assign pctl.pos   = pos_ff;

   drs_pick u_pick (
      .ctl  (pctl),
      .best (best_ff),
      .cand (rd_data),
      .res  (pres)
   );

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      drop_in     = drop_ff;
      marks_in    = marks_ff;
      pos_in      = pos_ff;
      total_in    = total_ff;
      step_in     = step_ff;
      scan_in     = scan_ff;
      iss_done_in = iss_done_ff;
      best_in     = best_ff;
      bidx_in     = bidx_ff;
      rv_in       = rv_ff;
      r_track_in  = r_track_ff;
      r_dist_in   = r_dist_ff;
      r_total_in  = r_total_ff;
      r_final_in  = r_final_ff;
      n_last      = cnt_ff - CW'(1);
      scan_last   = (CW'(scan_ff) == n_last);
      rd_vld_in   = (state_ff == S_SCAN) && !iss_done_ff;
      rd_idx_in   = scan_ff;
      cand        = rd_vld_ff && !marks_ff[rd_idx_ff];
      sum         = '0;

      unique case (state_ff)
         S_LOAD: begin
            if (req_xfer) begin
               if (cnt_ff < CNT_MAX) begin
                  cnt_in = cnt_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_port.last_request) begin
                  state_in    = S_SCAN;
                  pos_in      = start_ff & TMASK;
                  total_in    = '0;
                  step_in     = '0;
                  scan_in     = '0;
                  iss_done_in = 1'b0;
                  best_in     = '0;
               end
            end
         end
         S_SCAN: begin
            if (!iss_done_ff) begin
               if (scan_last) begin
                  iss_done_in = 1'b1;
               end else begin
                  scan_in = scan_ff + IW'(1);
               end
            end
            if (cand && pres.take) begin
               best_in.found = 1'b1;
               best_in.val   = rd_data;
               best_in.span  = pres.span;
               best_in.in_a  = pres.in_a;
               bidx_in       = rd_idx_ff;
            end
            // last read is in: serve the winner
            if (rd_vld_ff && (CW'(rd_idx_ff) == n_last)) begin
               sum        = (TOTAL_W+1)'(total_ff) + (TOTAL_W+1)'(best_in.span);
               total_in   = (sum > (TOTAL_W+1)'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
               marks_in[bidx_in] = 1'b1;
               pos_in     = best_in.val;
               rv_in      = 1'b1;
               r_track_in = best_in.val;
               r_dist_in  = best_in.span;
               r_total_in = total_in;
               r_final_in = (step_ff == n_last);
               step_in    = step_ff + CW'(1);
               state_in   = S_EMIT;
            end
         end
         S_EMIT: begin
            if (rsp_xfer) begin
               rv_in = 1'b0;
               if (r_final_ff) begin
                  cnt_in   = '0;
                  drop_in  = 1'b0;
                  marks_in = '0;
                  state_in = S_LOAD;
               end else begin
                  scan_in     = '0;
                  iss_done_in = 1'b0;
                  best_in     = '0;
                  state_in    = S_SCAN;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      bidx_ff    <= bidx_in;
      r_track_ff <= r_track_in;
      r_dist_ff  <= r_dist_in;
      r_total_ff <= r_total_in;
      r_final_ff <= r_final_in;
      if (reset) begin
         state_ff    <= S_LOAD;
         alg_ff      <= ALG_FCFS;
         start_ff    <= '0;
         dir_ff      <= 1'b0;
         cnt_ff      <= '0;
         drop_ff     <= 1'b0;
         marks_ff    <= '0;
         pos_ff      <= '0;
         total_ff    <= '0;
         step_ff     <= '0;
         scan_ff     <= '0;
         iss_done_ff <= 1'b0;
         rd_vld_ff   <= 1'b0;
         best_ff     <= '0;
         rv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         drop_ff     <= drop_in;
         marks_ff    <= marks_in;
         pos_ff      <= pos_in;
         total_ff    <= total_in;
         step_ff     <= step_in;
         scan_ff     <= scan_in;
         iss_done_ff <= iss_done_in;
         rd_vld_ff   <= rd_vld_in;
         best_ff     <= best_in;
         rv_ff       <= rv_in;
         if (csr_port.valid) begin
            unique case (csr_port.index)
               REG_ALGORITHM:   alg_ff   <= alg_type'(csr_port.data[ALG_W-1:0]);
               REG_START_TRACK: start_ff <= csr_port.data[TRACK_W-1:0];
               REG_DIRECTION:   dir_ff   <= csr_port.data[0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_port.valid         = rv_ff;
   assign rsp_port.served_track  = r_track_ff;
   assign rsp_port.move_distance = r_dist_ff;
   assign rsp_port.total_seek    = r_total_ff;
   assign rsp_port.final_result  = r_final_ff;
   assign rsp_port.overflow      = drop_ff;
endmodule

[sv/drs_checker.sv]
// Port-level checks of the disk request scheduler, bound to the top level.
// Depends on drs_pkg.
module drs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [drs_pkg::DIST_W-1:0]   move_distance,
   input logic [drs_pkg::TOTAL_W-1:0]  total_seek,
   input logic                         final_result
);
   import drs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(total_seek))
      else $error("result dropped or changed while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   a_total_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (TOTAL_W'(move_distance) <= total_seek))
      else $error("seek total below this move");

   a_batch_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !final_result |=> !req_ready)
      else $error("batch closed before its final result");
endmodule

bind disk_request_scheduler drs_checker u_drs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_port.ready),
   .rsp_valid     (rsp_port.valid),
   .rsp_ready     (rsp_port.ready),
   .move_distance (rsp_port.move_distance),
   .total_seek    (rsp_port.total_seek),
   .final_result  (rsp_port.final_result)
);

[test/tb.sv]
// Testbench for disk_request_scheduler: drives request batches and register
// writes, predicts the service order and checks every result transfer.
// Depends on drs_pkg, drs_if and the scheduler RTL.
`timescale 1ns / 100ps

class seek_board;
   typedef struct {
      logic [15:0] trk;
      logic [15:0] mv;
      logic [20:0] total;
      logic        fin;
      logic        ovf;
   } served_type;

   served_type  pending[$];
   logic [15:0] store[32];
   int          count;
   bit          dropped;
   drs_pkg::alg_type alg;
   logic [15:0] start;
   bit          dir;
   int          errors;

   function new();
      count = 0; dropped = 0; alg = drs_pkg::ALG_FCFS; start = 0; dir = 0;
      errors = 0;
   endfunction

   function void set_reg(drs_pkg::reg_idx_type idx, logic [15:0] val);
      case (idx)
         drs_pkg::REG_ALGORITHM:   alg = drs_pkg::alg_type'(val[1:0]);
         drs_pkg::REG_START_TRACK: start = val;
         drs_pkg::REG_DIRECTION:   dir = val[0];
         default: ;
      endcase
   endfunction

   function int gap(int a, int b);
      return a > b ? a - b : b - a;
   endfunction

   // note one accepted request; closing requests produce the whole order
   function void note_request(logic [15:0] trk, bit last);
      int ord[32], srt[32];
      bit taken[32];
      int n, k, i, j, x, split, pos, best, bd, bv, d, tot;
      bit take, found;
      served_type r;
      if (count < 32) begin
         store[count] = trk;
         count++;
      end else dropped = 1;
      if (!last) return;
      n = count;
      pos = start;
      for (i = 0; i < 32; i++) taken[i] = 0;
      if (alg == drs_pkg::ALG_FCFS) begin
         for (k = 0; k < n; k++) ord[k] = k;
      end else if (alg == drs_pkg::ALG_SSTF) begin
         for (k = 0; k < n; k++) begin
            found = 0; best = 0; bd = 0; bv = 0;
            for (i = 0; i < n; i++) begin
               if (taken[i]) continue;
               d = gap(store[i], pos);
               if (!found) take = 1;
               else if (d < bd) take = 1;
               else if (d == bd) take = dir ? (store[i] > bv) : (store[i] < bv);
               else take = 0;
               if (take) begin
                  found = 1; best = i; bd = d; bv = store[i];
               end
            end
            taken[best] = 1;
            ord[k] = best;
            pos = bv;
         end
      end else begin
         for (i = 0; i < n; i++) begin
            x = i; j = i;
            while (j > 0 && store[srt[j-1]] > store[x]) begin
               srt[j] = srt[j-1];
               j--;
            end
            srt[j] = x;
         end
         k = 0; split = 0;
         if (dir) begin
            while (split < n && store[srt[split]] < pos) split++;
            for (i = split; i < n; i++) ord[k++] = srt[i];
            if (alg == drs_pkg::ALG_CLOOK) for (i = 0; i < split; i++) ord[k++] = srt[i];
            else for (i = split; i > 0; i--) ord[k++] = srt[i-1];
         end else begin
            while (split < n && store[srt[split]] <= pos) split++;
            for (i = split; i > 0; i--) ord[k++] = srt[i-1];
            if (alg == drs_pkg::ALG_CLOOK) for (i = n; i > split; i--) ord[k++] = srt[i-1];
            else for (i = split; i < n; i++) ord[k++] = srt[i];
         end
      end
      pos = start; tot = 0;
      for (k = 0; k < n; k++) begin
         r.trk = store[ord[k]];
         d = gap(r.trk, pos);
         tot += d;
         if (tot > 2097151) tot = 2097151;
         r.mv = 16'(d); r.total = 21'(tot); r.fin = (k + 1 == n); r.ovf = dropped;
         pending.insert(pending.size(), r);
         pos = r.trk;
      end
      count = 0; dropped = 0;
   endfunction

   task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
   endtask

   task check_result(logic [15:0] trk, logic [15:0] mv, logic [20:0] tot,
                     logic fin, logic ovf);
      served_type e;
      if (pending.size() == 0) begin
         report("unexpected result, track", trk, 0);
         return;
      end
      e = pending.pop_front();
      if (trk !== e.trk) report("served_track", trk, e.trk);
      if (mv !== e.mv) report("move_distance", mv, e.mv);
      if (tot !== e.total) report("total_seek", tot, e.total);
      if (fin !== e.fin) report("final_result", fin, e.fin);
      if (ovf !== e.ovf) report("overflow", ovf, e.ovf);
   endtask
endclass

module tb;
   import drs_pkg::*;

   logic clock = 0;
   logic reset = 1;
   drs_req_if req_ch();
   drs_rsp_if rsp_ch();
   drs_csr_if csr_ch();
   seek_board board = new();
   int rsp_stall_mode = 0;

   disk_request_scheduler DUT (
      .clock(clock), .reset(reset),
      .req_port(req_ch.sink), .rsp_port(rsp_ch.source), .csr_port(csr_ch.sink)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      req_ch.valid = 0; req_ch.track = 0; req_ch.last_request = 0;
      csr_ch.valid = 0; csr_ch.index = REG_ALGORITHM; csr_ch.data = 0;
      rsp_ch.ready = 0;
   end

   // receiver: stall pattern changes per mode, check on each transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_result(rsp_ch.served_track, rsp_ch.move_distance,
                               rsp_ch.total_seek, rsp_ch.final_result, rsp_ch.overflow);
         case (rsp_stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(3) != 0);
            default: rsp_ch.ready <= ($urandom_range(3) == 0);
         endcase
      end
   end

   task automatic write_reg(reg_idx_type idx, logic [15:0] val);
      csr_ch.valid <= 1'b1; csr_ch.index <= idx; csr_ch.data <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      board.set_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic send_request(logic [15:0] trk, bit last);
      req_ch.valid <= 1'b1; req_ch.track <= trk; req_ch.last_request <= last;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(trk, last);
      // drop valid only if a gap follows; the next call re-drives it otherwise
      if ($urandom_range(3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic send_batch(int n, int spread);
      logic [15:0] base;
      int i;
      base = 16'($urandom);
      for (i = 0; i < n; i++)
         send_request(spread ? 16'($urandom) : 16'(base + $urandom_range(6)), i == n - 1);
   endtask

   initial begin
      int a, n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: each order, extremes, ties, head on a request, full store
      for (a = 0; a < 4; a++) begin
         write_reg(REG_ALGORITHM, 16'(a));
         write_reg(REG_START_TRACK, 16'd100);
         write_reg(REG_DIRECTION, 16'(a & 1));
         send_request(16'd90, 0); send_request(16'd110, 0);
         send_request(16'd100, 0); send_request(16'hFFFF, 0);
         send_request(16'd0, 1);
         drain();
      end
      write_reg(REG_DIRECTION, 16'd0);
      send_request(16'd200, 0); send_request(16'd300, 1);
      drain();
      write_reg(REG_ALGORITHM, 16'(ALG_LOOK));
      send_request(16'd5, 1);
      drain();
      // store full: 34 requests, all at extremes, totals just below the saturation limit
      write_reg(REG_ALGORITHM, 16'(ALG_FCFS));
      write_reg(REG_START_TRACK, 16'hFFFF);
      for (a = 0; a < 34; a++) send_request(a[0] ? 16'hFFFF : 16'h0000, a == 33);
      drain();
      // random phases
      while (board.pending.size() == 0 && a < 460) begin
         write_reg(REG_ALGORITHM, 16'($urandom_range(3)));
         write_reg(REG_START_TRACK, $urandom_range(1) ? 16'($urandom) :
                   ($urandom_range(1) ? 16'hFFFF : 16'h0000));
         write_reg(REG_DIRECTION, 16'($urandom_range(1)));
         rsp_stall_mode = $urandom_range(2);
         n = ($urandom_range(15) == 0) ? $urandom_range(32, 36) : $urandom_range(1, 10);
         send_batch(n, $urandom_range(2) != 0);
         a += n;
         drain();
      end
      rsp_stall_mode = 0;
      drain();
      if (board.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
